>>> rtl/core/rsps_pkg.sv
package rsps_pkg;

    localparam int SEG_NUM      = 5;
    localparam int LEN_W        = 32;
    localparam int FRAC_BITS    = 16;
    localparam int ANG_BITS     = 30;
    localparam int ANG_SHIFT    = ANG_BITS - FRAC_BITS;
    localparam int HW           = 36;
    localparam int MAG_W        = HW + ANG_SHIFT;
    localparam int MOD_STEPS    = 18;
    localparam int ZW           = 34;
    localparam int CORDIC_STEPS = 16;
    localparam int TRIG_W       = ZW - ANG_SHIFT;
    localparam int TRIG_LAT     = MOD_STEPS + CORDIC_STEPS + 4;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int RAD_W        = 31;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_LEFT     = 2'd1;
    localparam logic [1:0] KIND_RIGHT    = 2'd2;
    localparam logic [1:0] KIND_STRAIGHT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SEG_PAIR_A  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_PAIR_B  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_LAST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_KINDS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_RADIUS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_X     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_START_HEAD  = 3'd7;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 31'd65536;

    localparam logic [MAG_W-1:0]  TWO_PI_MAG = 50'd6746518852;
    localparam logic signed [ZW-1:0] TWO_PI_Q30 = 34'sd6746518852;
    localparam logic signed [ZW-1:0] PI_Q30     = 34'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ZW-1:0] GAIN_Q30   = 34'sd652032874;

    localparam logic signed [ZW-1:0] ATAN_TAB [0:23] = '{
        34'sd843314857, 34'sd497837830, 34'sd263043837, 34'sd133525159,
        34'sd67021688, 34'sd33543515, 34'sd16775851, 34'sd8388438,
        34'sd4194293, 34'sd2097149, 34'sd1048576, 34'sd524288,
        34'sd262144, 34'sd131072, 34'sd65536, 34'sd32768,
        34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048,
        34'sd1024, 34'sd512, 34'sd256, 34'sd128
    };

    typedef struct packed {
        logic [SEG_NUM-1:0][LEN_W-1:0] seg_len;
        logic [2*SEG_NUM-1:0]          kinds;
        logic [RAD_W-1:0]              radius;
        logic [31:0]                   start_x;
        logic [31:0]                   start_y;
        logic [31:0]                   start_heading;
    } cfg_t;

    typedef struct packed {
        logic [SEG_NUM:0][HW-1:0]      hd;
        logic [SEG_NUM-1:0][LEN_W-1:0] v;
        logic [SEG_NUM-1:0][1:0]       kind;
    } walk_t;

    typedef struct packed {
        logic [SEG_NUM-1:0][LEN_W-1:0] v;
        logic [SEG_NUM-1:0][1:0]       kind;
        logic [HW-1:0]                 hfin;
    } side_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] val);
        if (val > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (val < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return val[31:0];
    endfunction

endpackage

>>> rtl/core/reeds_shepp_pose_sampler.sv
// Channel   Direction  Signals
// request   in         s_valid, s_ready, s_arc_length
// result    out        m_valid, m_ready, m_pos_x, m_pos_y, m_heading
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One request is taken per cycle while the queue is not full.
// Most of the latency lies in the six sine and cosine pipelines: 18 modulo steps and 16 CORDIC steps.
// A synchronous low reset clears all valid state and loads the register reset values.
// A stalled result holds the back pipeline; the four-entry queue then fills and stops requests.
module reeds_shepp_pose_sampler import rsps_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [LEN_W-1:0] s_arc_length,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [31:0]      m_pos_x,
    output logic signed [31:0]      m_pos_y,
    output logic signed [31:0]      m_heading,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    cfg_t  cfg_reg;
    logic  fifo_push;
    logic  fifo_full;
    logic  fifo_pop;
    logic  fifo_empty;
    walk_t fifo_din;
    walk_t fifo_dout;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{seg_len: '0, kinds: '0, radius: RADIUS_RESET, start_x: '0,
                         start_y: '0, start_heading: '0};
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SEG_PAIR_A: begin
                    cfg_reg.seg_len[0] <= cfg_data[31:0];
                    cfg_reg.seg_len[1] <= cfg_data[63:32];
                end
                REG_SEG_PAIR_B: begin
                    cfg_reg.seg_len[2] <= cfg_data[31:0];
                    cfg_reg.seg_len[3] <= cfg_data[63:32];
                end
                REG_SEG_LAST:    cfg_reg.seg_len[4]    <= cfg_data[31:0];
                REG_SEG_KINDS:   cfg_reg.kinds         <= cfg_data[2*SEG_NUM-1:0];
                REG_TURN_RADIUS: cfg_reg.radius        <= cfg_data[RAD_W-1:0];
                REG_START_X:     cfg_reg.start_x       <= cfg_data[31:0];
                REG_START_Y:     cfg_reg.start_y       <= cfg_data[31:0];
                REG_START_HEAD:  cfg_reg.start_heading <= cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    rsps_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_arc_length (s_arc_length),
        .q_full       (fifo_full),
        .q_push       (fifo_push),
        .q_data       (fifo_din)
    );

    rsps_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fifo_push),
        .din     (fifo_din),
        .full    (fifo_full),
        .pop     (fifo_pop),
        .dout    (fifo_dout),
        .empty   (fifo_empty)
    );

    rsps_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_empty   (fifo_empty),
        .q_data    (fifo_dout),
        .q_pop     (fifo_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_pos_x   (m_pos_x),
        .m_pos_y   (m_pos_y),
        .m_heading (m_heading)
    );

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && fifo_empty)
        else $error("reset did not clear the result and the queue");

    a_queue_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_full |-> !fifo_empty)
        else $error("queue reports full and empty together");

    a_pop_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_pop |-> !m_valid || m_ready)
        else $error("queue popped while the result is stalled");

endmodule

>>> rtl/core/rsps_front.sv
module rsps_front import rsps_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [LEN_W-1:0] s_arc_length,
    input  logic                    q_full,
    output logic                    q_push,
    output walk_t                   q_data
);

    logic                    en;
    logic [SEG_NUM:0]        vld_reg;
    logic signed [LEN_W-1:0] rem_reg [SEG_NUM];
    walk_t                   walk_reg [SEG_NUM+1];
    walk_t                   walk_init;
    walk_t                   walk_nx [SEG_NUM];
    logic signed [LEN_W-1:0] rem_nx [SEG_NUM];
    logic signed [LEN_W-1:0] len_w [SEG_NUM];
    logic signed [LEN_W-1:0] v_w [SEG_NUM];
    logic signed [HW-1:0]    dh_w [SEG_NUM];

    assign en      = !q_full;
    assign s_ready = en;
    assign q_push  = en && vld_reg[SEG_NUM];
    assign q_data  = walk_reg[SEG_NUM];

    always_comb begin
        walk_init = '0;
        walk_init.hd[0] = HW'($signed(cfg.start_heading));
    end

    always_comb begin
        for (int j = 0; j < SEG_NUM; j++) begin
            len_w[j] = $signed(cfg.seg_len[j]);
            if (rem_reg[j] > 0) begin
                if (len_w[j] < 0) begin
                    v_w[j]    = (-rem_reg[j] > len_w[j]) ? -rem_reg[j] : len_w[j];
                    rem_nx[j] = rem_reg[j] + v_w[j];
                end else begin
                    v_w[j]    = (rem_reg[j] < len_w[j]) ? rem_reg[j] : len_w[j];
                    rem_nx[j] = rem_reg[j] - v_w[j];
                end
            end else begin
                v_w[j]    = '0;
                rem_nx[j] = rem_reg[j];
            end
            case (cfg.kinds[2*j +: 2])
                KIND_LEFT:  dh_w[j] = HW'(v_w[j]);
                KIND_RIGHT: dh_w[j] = -HW'(v_w[j]);
                default:    dh_w[j] = '0;
            endcase
            walk_nx[j]           = walk_reg[j];
            walk_nx[j].v[j]      = v_w[j];
            walk_nx[j].kind[j]   = cfg.kinds[2*j +: 2];
            walk_nx[j].hd[j+1]   = $signed(walk_reg[j].hd[j]) + dh_w[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[SEG_NUM-1:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= s_arc_length;
            walk_reg[0] <= walk_init;
            for (int j = 0; j < SEG_NUM; j++) begin
                walk_reg[j+1] <= walk_nx[j];
            end
            for (int j = 0; j < SEG_NUM - 1; j++) begin
                rem_reg[j+1] <= rem_nx[j];
            end
        end
    end

endmodule

>>> rtl/core/rsps_fifo.sv
module rsps_fifo import rsps_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  walk_t din,
    output logic  full,
    input  logic  pop,
    output walk_t dout,
    output logic  empty
);

    walk_t                 mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   cnt_reg;

    assign full  = (cnt_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/rsps_sincos.sv
module rsps_sincos import rsps_pkg::*; (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [HW-1:0]     angle,
    output logic signed [TRIG_W-1:0] sin_out,
    output logic signed [TRIG_W-1:0] cos_out
);

    logic [HW-1:0]           abs_ang;
    logic [MAG_W-1:0]        mag_reg [MOD_STEPS+1];
    logic                    neg_reg [MOD_STEPS+1];
    logic signed [ZW-1:0]    m_s;
    logic signed [ZW-1:0]    wrap_t;
    logic signed [ZW-1:0]    wrap_reg;
    logic signed [ZW-1:0]    fold_z;
    logic                    fold_neg;
    logic signed [ZW-1:0]    x_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0]    y_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0]    z_reg [CORDIC_STEPS+1];
    logic                    negc_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0]    x_fin;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;

    assign abs_ang = angle[HW-1] ? -angle : angle;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg[0] <= {abs_ang, {ANG_SHIFT{1'b0}}};
            neg_reg[0] <= angle[HW-1];
        end
    end

    for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
        localparam logic [MAG_W-1:0] SUB = TWO_PI_MAG << (MOD_STEPS - 1 - k);
        always_ff @(posedge aclk) begin
            if (en) begin
                mag_reg[k+1] <= (mag_reg[k] >= SUB) ? mag_reg[k] - SUB : mag_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    assign m_s    = $signed({1'b0, mag_reg[MOD_STEPS][ZW-2:0]});
    assign wrap_t = (m_s > PI_Q30) ? m_s - TWO_PI_Q30 : m_s;

    always_comb begin
        if (wrap_reg > HALF_PI_Q30) begin
            fold_z   = PI_Q30 - wrap_reg;
            fold_neg = 1'b1;
        end else if (wrap_reg < -HALF_PI_Q30) begin
            fold_z   = -PI_Q30 - wrap_reg;
            fold_neg = 1'b1;
        end else begin
            fold_z   = wrap_reg;
            fold_neg = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wrap_reg    <= neg_reg[MOD_STEPS] ? -wrap_t : wrap_t;
            x_reg[0]    <= GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= fold_z;
            negc_reg[0] <= fold_neg;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
                end
                negc_reg[i+1] <= negc_reg[i];
            end
        end
    end

    assign x_fin = negc_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= TRIG_W'(y_reg[CORDIC_STEPS] >>> ANG_SHIFT);
            cos_reg <= TRIG_W'(x_fin >>> ANG_SHIFT);
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

>>> rtl/core/rsps_back.sv
module rsps_back import rsps_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               q_empty,
    input  walk_t              q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_heading
);

    localparam int VLD_N  = TRIG_LAT + 5;
    localparam int PROD_W = LEN_W + TRIG_W;
    localparam int TERM_W = PROD_W - FRAC_BITS;
    localparam int NPAIR  = (SEG_NUM + 1) / 2;
    localparam int ACC_W  = TERM_W + 3;
    localparam int HI_W   = ACC_W - FRAC_BITS;
    localparam int PHI_W  = HI_W + RAD_W + 1;
    localparam int PLO_W  = FRAC_BITS + RAD_W;
    localparam int SC_W   = PHI_W + 1;

    logic                     en;
    logic [VLD_N-1:0]         vld_reg;
    side_t                    side_in;
    side_t                    side_reg [TRIG_LAT];
    logic signed [TRIG_W-1:0] sn [SEG_NUM+1];
    logic signed [TRIG_W-1:0] cs [SEG_NUM+1];

    logic signed [TRIG_W:0]   adx_reg [SEG_NUM];
    logic signed [TRIG_W:0]   ady_reg [SEG_NUM];
    logic signed [PROD_W-1:0] pc_reg [SEG_NUM];
    logic signed [PROD_W-1:0] ps_reg [SEG_NUM];
    logic [SEG_NUM-1:0][1:0]  kind_p_reg;
    logic [HW-1:0]            hp_reg;

    logic signed [TERM_W-1:0] tx [2*NPAIR];
    logic signed [TERM_W-1:0] ty [2*NPAIR];
    logic signed [ACC_W-1:0]  px_reg [NPAIR];
    logic signed [ACC_W-1:0]  py_reg [NPAIR];
    logic [HW-1:0]            hq1_reg;

    logic signed [ACC_W-1:0]  ax_reg;
    logic signed [ACC_W-1:0]  ay_reg;
    logic [HW-1:0]            hq2_reg;

    logic signed [PHI_W-1:0]  phx_reg;
    logic signed [PHI_W-1:0]  phy_reg;
    logic [PLO_W-1:0]         plx_reg;
    logic [PLO_W-1:0]         ply_reg;
    logic [HW-1:0]            hs1_reg;

    logic signed [SC_W-1:0]   scx_reg;
    logic signed [SC_W-1:0]   scy_reg;
    logic [HW-1:0]            hs2_reg;

    logic                     m_valid_reg;
    logic [31:0]              pos_x_reg;
    logic [31:0]              pos_y_reg;
    logic [31:0]              head_reg;

    assign en    = !m_valid_reg || m_ready;
    assign q_pop = en && !q_empty;

    assign side_in.v    = q_data.v;
    assign side_in.kind = q_data.kind;
    assign side_in.hfin = q_data.hd[SEG_NUM];

    for (genvar k = 0; k <= SEG_NUM; k++) begin : g_trig
        rsps_sincos u_sincos (
            .aclk    (aclk),
            .en      (en),
            .angle   ($signed(q_data.hd[k])),
            .sin_out (sn[k]),
            .cos_out (cs[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[VLD_N-2:0], q_pop};
            m_valid_reg <= vld_reg[VLD_N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int k = 1; k < TRIG_LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < SEG_NUM; j++) begin
                adx_reg[j] <= sn[j+1] - sn[j];
                ady_reg[j] <= cs[j] - cs[j+1];
                pc_reg[j]  <= $signed(side_reg[TRIG_LAT-1].v[j]) * cs[j];
                ps_reg[j]  <= $signed(side_reg[TRIG_LAT-1].v[j]) * sn[j];
            end
            kind_p_reg <= side_reg[TRIG_LAT-1].kind;
            hp_reg     <= side_reg[TRIG_LAT-1].hfin;
        end
    end

    always_comb begin
        for (int j = 0; j < 2 * NPAIR; j++) begin
            tx[j] = '0;
            ty[j] = '0;
            if (j < SEG_NUM) begin
                case (kind_p_reg[j])
                    KIND_LEFT: begin
                        tx[j] = TERM_W'(adx_reg[j]);
                        ty[j] = TERM_W'(ady_reg[j]);
                    end
                    KIND_RIGHT: begin
                        tx[j] = -TERM_W'(adx_reg[j]);
                        ty[j] = -TERM_W'(ady_reg[j]);
                    end
                    KIND_STRAIGHT: begin
                        tx[j] = TERM_W'(pc_reg[j] >>> FRAC_BITS);
                        ty[j] = TERM_W'(ps_reg[j] >>> FRAC_BITS);
                    end
                    default: begin
                        tx[j] = '0;
                        ty[j] = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NPAIR; k++) begin
                px_reg[k] <= ACC_W'(tx[2*k]) + ACC_W'(tx[2*k+1]);
                py_reg[k] <= ACC_W'(ty[2*k]) + ACC_W'(ty[2*k+1]);
            end
            hq1_reg <= hp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [ACC_W-1:0] sx;
        logic signed [ACC_W-1:0] sy;
        sx = '0;
        sy = '0;
        for (int k = 0; k < NPAIR; k++) begin
            sx = sx + px_reg[k];
            sy = sy + py_reg[k];
        end
        if (en) begin
            ax_reg  <= sx;
            ay_reg  <= sy;
            hq2_reg <= hq1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            phx_reg <= $signed(ax_reg[ACC_W-1:FRAC_BITS]) * $signed({1'b0, cfg.radius});
            phy_reg <= $signed(ay_reg[ACC_W-1:FRAC_BITS]) * $signed({1'b0, cfg.radius});
            plx_reg <= ax_reg[FRAC_BITS-1:0] * cfg.radius;
            ply_reg <= ay_reg[FRAC_BITS-1:0] * cfg.radius;
            hs1_reg <= hq2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            scx_reg <= SC_W'(phx_reg) + SC_W'($signed({1'b0, plx_reg[PLO_W-1:FRAC_BITS]}));
            scy_reg <= SC_W'(phy_reg) + SC_W'($signed({1'b0, ply_reg[PLO_W-1:FRAC_BITS]}));
            hs2_reg <= hs1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_x_reg <= sat32(64'(scx_reg) + 64'($signed(cfg.start_x)));
            pos_y_reg <= sat32(64'(scy_reg) + 64'($signed(cfg.start_y)));
            head_reg  <= sat32(64'($signed(hs2_reg)));
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_pos_x   = pos_x_reg;
    assign m_pos_y   = pos_y_reg;
    assign m_heading = head_reg;

endmodule
